/* design/assert_macros.svh */
// Assertion macros used by the checker module.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/cpwp_pkg.sv */
// Types, constants and helper functions for the calibration packet word placer.
// No dependencies; used by every module of the block.
`default_nettype none

package cpwp_pkg;

    localparam int IFOVS_PER_PACKET = 5;
    localparam int BANDS_250M       = 2;
    localparam int BANDS_500M       = 5;
    localparam int BANDS_1KM_DAY    = 15;
    localparam int BANDS_1KM_NIGHT  = 16;
    localparam int HALF_OFFSET      = 5;
    localparam int SCAN_IFOVS       = 2 * HALF_OFFSET;

    typedef enum logic [1:0] {
        SEC_250M,
        SEC_500M,
        SEC_1KM_DAY,
        SEC_1KM_NIGHT
    } cpwp_sec_t;

    typedef struct packed {
        logic [11:0] raw_word;
        logic        packet_start;
        logic [6:0]  frame_count;
        logic        second_half;
    } cpwp_in_t;

    typedef struct packed {
        logic [11:0] stored_word;
        logic [1:0]  target_array;
        logic [5:0]  line_index;
        logic [3:0]  band_index;
        logic [8:0]  frame_index;
        logic        packet_end;
    } cpwp_out_t;

    // counter state in effect for the word being placed
    typedef struct packed {
        logic [2:0] ifov;
        cpwp_sec_t  section;
        logic [3:0] band;
        logic [1:0] sample;
        logic [1:0] det;
        logic [6:0] frame_count;
        logic       second_half;
    } cpwp_ctx_t;

    // samples per band and detectors per ifov
    function automatic logic [2:0] sec_ratio(input cpwp_sec_t sec);
        logic [2:0] r;
        case (sec)
            SEC_250M: r = 3'd4;
            SEC_500M: r = 3'd2;
            default:  r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] sec_bands(input cpwp_sec_t sec);
        logic [4:0] b;
        case (sec)
            SEC_250M:    b = 5'(BANDS_250M);
            SEC_500M:    b = 5'(BANDS_500M);
            SEC_1KM_DAY: b = 5'(BANDS_1KM_DAY);
            default:     b = 5'(BANDS_1KM_NIGHT);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* design/cpwp_counters.sv */
// Nested packet counters and latched header fields of the word placer.
// Depends on cpwp_pkg.
`default_nettype none

module cpwp_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  cpwp_pkg::cpwp_in_t item,
    output cpwp_pkg::cpwp_ctx_t ctx
);
    import cpwp_pkg::*;

    logic [2:0] ifov_reg,   ifov_next;
    cpwp_sec_t  section_reg, section_next;
    logic [3:0] band_reg,   band_next;
    logic [1:0] sample_reg, sample_next;
    logic [1:0] det_reg,    det_next;
    logic [6:0] fc_reg;
    logic       half_reg;

    logic [2:0] ratio;
    logic [2:0] det_inc;
    logic [2:0] sample_inc;
    logic [4:0] band_inc;
    logic [3:0] ifov_inc;

    // a start word clears the counters before it is placed
    always_comb
    begin
        if (item.packet_start)
        begin
            ctx.ifov        = '0;
            ctx.section     = SEC_250M;
            ctx.band        = '0;
            ctx.sample      = '0;
            ctx.det         = '0;
            ctx.frame_count = item.frame_count;
            ctx.second_half = item.second_half;
        end
        else
        begin
            ctx.ifov        = ifov_reg;
            ctx.section     = section_reg;
            ctx.band        = band_reg;
            ctx.sample      = sample_reg;
            ctx.det         = det_reg;
            ctx.frame_count = fc_reg;
            ctx.second_half = half_reg;
        end
    end

    assign ratio      = sec_ratio(ctx.section);
    assign det_inc    = {1'b0, ctx.det} + 3'd1;
    assign sample_inc = {1'b0, ctx.sample} + 3'd1;
    assign band_inc   = {1'b0, ctx.band} + 5'd1;
    assign ifov_inc   = {1'b0, ctx.ifov} + 4'd1;

    always_comb
    begin
        ifov_next    = ctx.ifov;
        section_next = ctx.section;
        band_next    = ctx.band;
        sample_next  = ctx.sample;
        det_next     = det_inc[1:0];
        if (det_inc >= ratio)
        begin
            det_next    = '0;
            sample_next = sample_inc[1:0];
            if (sample_inc >= ratio)
            begin
                sample_next = '0;
                band_next   = band_inc[3:0];
                if (band_inc >= sec_bands(ctx.section))
                begin
                    band_next    = '0;
                    section_next = cpwp_sec_t'(ctx.section + 2'd1);
                    if (ctx.section == SEC_1KM_NIGHT)
                    begin
                        ifov_next = ifov_inc[2:0];
                        if (ifov_inc >= 4'(IFOVS_PER_PACKET))
                            ifov_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ifov_reg    <= '0;
            section_reg <= SEC_250M;
            band_reg    <= '0;
            sample_reg  <= '0;
            det_reg     <= '0;
            fc_reg      <= 7'd1;
            half_reg    <= 1'b0;
        end
        else if (advance)
        begin
            ifov_reg    <= ifov_next;
            section_reg <= section_next;
            band_reg    <= band_next;
            sample_reg  <= sample_next;
            det_reg     <= det_next;
            fc_reg      <= ctx.frame_count;
            half_reg    <= ctx.second_half;
        end
    end

endmodule

`default_nettype wire

/* design/cpwp_place.sv */
// Placement logic: array, line, band and frame coordinates of one word.
// Purely combinational; depends on cpwp_pkg.
`default_nettype none

module cpwp_place (
    input  cpwp_pkg::cpwp_in_t  item,
    input  cpwp_pkg::cpwp_ctx_t ctx,
    output cpwp_pkg::cpwp_out_t result
);
    import cpwp_pkg::*;

    logic [3:0] ifov_in_scan;
    logic [8:0] fc_m1;
    logic [5:0] line;
    logic [8:0] frame;
    logic [3:0] ifov_inc;
    logic [4:0] band_inc;

    assign ifov_in_scan = {1'b0, ctx.ifov} + (ctx.second_half ? 4'(HALF_OFFSET) : 4'd0);
    // frame count zero wraps to all ones
    assign fc_m1     = {2'b00, ctx.frame_count} - 9'd1;
    assign ifov_inc  = {1'b0, ctx.ifov} + 4'd1;
    assign band_inc  = {1'b0, ctx.band} + 5'd1;

    // lines run in reverse detector order across the scan
    always_comb
    begin
        case (ctx.section)
            SEC_250M:
            begin
                line  = 6'(4 * SCAN_IFOVS - 1)
                      - ({ifov_in_scan, 2'b00} + {4'b0000, ctx.det});
                frame = {fc_m1[6:0], 2'b00} + {7'd0, ctx.sample};
            end
            SEC_500M:
            begin
                line  = 6'(2 * SCAN_IFOVS - 1)
                      - ({1'b0, ifov_in_scan, 1'b0} + {4'b0000, ctx.det});
                frame = {fc_m1[7:0], 1'b0} + {7'd0, ctx.sample};
            end
            default:
            begin
                line  = 6'(SCAN_IFOVS - 1)
                      - ({2'b00, ifov_in_scan} + {4'b0000, ctx.det});
                frame = fc_m1 + {7'd0, ctx.sample};
            end
        endcase
    end

    always_comb
    begin
        result.stored_word  = item.raw_word;
        result.target_array = ctx.section;
        result.line_index   = line;
        result.band_index   = ctx.band;
        result.frame_index  = frame;
        result.packet_end   = (ifov_inc >= 4'(IFOVS_PER_PACKET))
                            && (ctx.section == SEC_1KM_NIGHT)
                            && (band_inc >= 5'(BANDS_1KM_NIGHT));
    end

endmodule

`default_nettype wire

/* design/calibration_packet_word_placer.sv */
// Calibration packet word placer, top level.
// Gives the storage place of each data word of a calibration-sector day packet.
// Channels: a word request (word_valid / word_stall / word) carries one data
// word with its packet_start flag and, on the start word, the header's frame
// count and second-half flag. A place request (place_valid / place_stall /
// place) returns the word with its target array, line, band and frame index,
// and flags the last word of the packet.
// Path: an accepted word is held in the input register and moves into the
// result register when that is free, and place shows it from there. One word
// per cycle sustained while place is not stalled; the counter update and the
// coordinate sums fit between the two registers.
// Both registers hold a request each, so an input word is still taken while
// one result waits under stall; the input stalls only when both are full.
// Reset clears the valid bits and the counters and sets the latched frame
// count to 1 and the half flag to first half. Words before any start word
// are placed with those values; words after the last are placed as a new
// packet with the latched header fields.
`default_nettype none

module calibration_packet_word_placer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    output logic                word_stall,
    input  cpwp_pkg::cpwp_in_t  word,
    output logic                place_valid,
    input  logic                place_stall,
    output cpwp_pkg::cpwp_out_t place
);
    import cpwp_pkg::*;

    logic      in_valid_reg, in_valid_next;
    cpwp_in_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    cpwp_out_t out_item_reg;

    logic      out_free;
    logic      move;
    logic      take;
    cpwp_ctx_t ctx;
    cpwp_out_t result;

    assign out_free   = !out_valid_reg || !place_stall;
    assign move       = in_valid_reg && out_free;
    assign word_stall = in_valid_reg && !out_free;
    assign take       = word_valid && !word_stall;

    cpwp_counters u_counters (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (move),
        .item    (in_item_reg),
        .ctx     (ctx)
    );

    cpwp_place u_place (
        .item   (in_item_reg),
        .ctx    (ctx),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (move)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (!place_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= word;
        if (move)
            out_item_reg <= result;
    end

    assign place_valid = out_valid_reg;
    assign place       = out_item_reg;

endmodule

`default_nettype wire

/* design/cpwp_checker.sv */
// Port-level checks for the calibration packet word placer, bound to the top.
// Depends on cpwp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cpwp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                place_valid,
    input logic                place_stall,
    input cpwp_pkg::cpwp_out_t place
);
    import cpwp_pkg::*;

    logic end_ok;
    logic line_ok;
    logic band_ok;

    // last word is always the final 1 km night band
    assign end_ok  = !(place_valid && place.packet_end)
                   || (place.target_array == 2'(SEC_1KM_NIGHT)
                       && place.band_index == 4'(BANDS_1KM_NIGHT - 1));
    // 1 km lines stay within the ten scan ifovs
    assign line_ok = !(place_valid && place.target_array[1])
                   || (place.line_index <= 6'(SCAN_IFOVS - 1));
    // 250 m bands stay within their group
    assign band_ok = !(place_valid && place.target_array == 2'(SEC_250M))
                   || (place.band_index < 4'(BANDS_250M));

    // a stalled result request holds
    `CHK_NEXT(a_hold, clk, rst_n, place_valid && place_stall, place_valid && $stable(place))

    `CHK_ALWAYS(a_end_band, clk, rst_n, end_ok)

    `CHK_ALWAYS(a_1km_line, clk, rst_n, line_ok)

    `CHK_ALWAYS(a_250m_band, clk, rst_n, band_ok)

endmodule

bind calibration_packet_word_placer cpwp_checker u_cpwp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .place_valid (place_valid),
    .place_stall (place_stall),
    .place       (place)
);

`default_nettype wire
